[rtl/vml_pkg.sv]
// ----------------------------------------------------------------------------
// Vector magnitude limiter package
// Shared constants for the magnitude limiter datapath.
// ----------------------------------------------------------------------------
package vml_pkg;

  localparam int unsigned FLOOR_W = 31;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);

endpackage

[rtl/vml_delay.sv]
// ----------------------------------------------------------------------------
// Delay line
// Shift register that keeps side data aligned with a pipelined unit.
// ----------------------------------------------------------------------------
module vml_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        tap_q[k] <= '0;
      end
    end else if (en_i) begin
      tap_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

[rtl/vml_mul.sv]
// ----------------------------------------------------------------------------
// Two-stage multiplier
// Unsigned product built from two registered partial products.
// ----------------------------------------------------------------------------
module vml_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;

  logic [AW+BL-1:0] plo_d, plo_q;
  logic [AW+BH-1:0] phi_d, phi_q;
  logic [AW+BW-1:0] p_d, p_q;

  assign plo_d = {{BL{1'b0}}, a_i} * {{AW{1'b0}}, b_i[BL-1:0]};
  assign phi_d = {{BH{1'b0}}, a_i} * {{AW{1'b0}}, b_i[BW-1:BL]};
  assign p_d   = {phi_q, {BL{1'b0}}} + {{BH{1'b0}}, plo_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/vml_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor of the root of a 2W-bit radicand.
// ----------------------------------------------------------------------------
module vml_sqrt #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  logic [2*W-1:0] rad_q  [W];
  logic [W-1:0]   root_q [W];
  logic [W:0]     rem_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] rad;
    logic [W-1:0]   root;
    logic [W:0]     rem;
    logic [W+2:0]   r;
    logic [W+2:0]   trial;
    logic [W+2:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad  = rad_i;
      assign root = '0;
      assign rem  = '0;
    end else begin : g_next
      assign rad  = rad_q[k-1];
      assign root = root_q[k-1];
      assign rem  = rem_q[k-1];
    end

    assign r     = {rem, rad[2*W-1:2*W-2]};
    assign trial = {1'b0, root, 2'b01};
    assign ge    = (r >= trial);
    assign diff  = r - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad[2*W-3:0], 2'b00};
        root_q[k] <= {root[W-2:0], ge};
        rem_q[k]  <= ge ? diff[W:0] : r[W:0];
      end
    end
  end

  assign root_o = root_q[W-1];

endmodule

[rtl/vml_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, truncating unsigned division.
// ----------------------------------------------------------------------------
module vml_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [DW:0]   r;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign nq  = num_i;
      assign rem = '0;
      assign den = den_i;
    end else begin : g_next
      assign nq  = nq_q[k-1];
      assign rem = rem_q[k-1];
      assign den = den_q[k-1];
    end

    assign r    = {rem, nq[NW-1]};
    assign ge   = (r >= {1'b0, den});
    assign diff = r - {1'b0, den};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq[NW-2:0], ge};
        rem_q[k] <= ge ? diff[DW-1:0] : r[DW-1:0];
        den_q[k] <= den;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

[rtl/vector_magnitude_limiter_top.sv]
// ----------------------------------------------------------------------------
// Vector magnitude limiter
// Stages: input register, two-stage multipliers, limit compare, one stage per
// root bit, one per quotient bit, output register.
// Throughput: one transfer per cycle; the whole pipeline holds while a result
// waits. Reset empties the pipeline and sets the floor register to one.
// ----------------------------------------------------------------------------
module vector_magnitude_limiter_top
  import vml_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [FLOOR_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] flux_x_i,
  input  logic [DATA_WIDTH-1:0] flux_y_i,
  input  logic [DATA_WIDTH-1:0] flux_z_i,
  input  logic [DATA_WIDTH-1:0] energy_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] out_x_o,
  output logic [DATA_WIDTH-1:0] out_y_o,
  output logic [DATA_WIDTH-1:0] out_z_o,
  output logic                  was_limited_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned NW  = 2 * W - 1;
  localparam int unsigned DW  = (W > FLOOR_W) ? W : FLOOR_W;
  localparam int unsigned SA  = 1 + 4 + 3 * W;
  localparam int unsigned SD  = 2 + 4 + 3 * NW + 3 * W;
  localparam int unsigned SS  = 2 + 4 + 3 * W;
  localparam logic [NW-1:0] SIGN_N = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAX_P  = {1'b0, {(W-1){1'b1}}};

  function automatic logic [W-1:0] sat(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] qs;
    qs = (q > SIGN_N) ? SIGN_N : q;
    if (q == '0) begin
      return '0;
    end else if (neg) begin
      return ~qs[W-1:0] + W'(1);
    end else if (q >= SIGN_N) begin
      return MAX_P;
    end else begin
      return q[W-1:0];
    end
  endfunction

  logic en;
  logic [FLOOR_W-1:0] floor_q;
  logic [FLOOR_W-1:0] floor_eff;

  // floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  assign floor_eff = (floor_q == '0) ? FLOOR_RESET : floor_q;

  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // input stage: split sign and magnitude
  logic         a_vld_q;
  logic [W-1:0] ax_q, ay_q, az_q, ae_q;
  logic         nx_q, ny_q, nz_q, ne_q;
  logic [W-1:0] rx_q, ry_q, rz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= flux_x_i[W-1];
      ny_q <= flux_y_i[W-1];
      nz_q <= flux_z_i[W-1];
      ne_q <= energy_i[W-1];
      ax_q <= flux_x_i[W-1] ? (~flux_x_i + W'(1)) : flux_x_i;
      ay_q <= flux_y_i[W-1] ? (~flux_y_i + W'(1)) : flux_y_i;
      az_q <= flux_z_i[W-1] ? (~flux_z_i + W'(1)) : flux_z_i;
      ae_q <= energy_i[W-1] ? (~energy_i + W'(1)) : energy_i;
      rx_q <= flux_x_i;
      ry_q <= flux_y_i;
      rz_q <= flux_z_i;
    end
  end

  // multiplier lanes
  logic [2*W-1:0] sqx, sqy, sqz, sqe, prx, pry, prz;

  vml_mul #(.AW(W), .BW(W)) u_sqx (.clk_i, .en_i(en), .a_i(ax_q), .b_i(ax_q), .p_o(sqx));
  vml_mul #(.AW(W), .BW(W)) u_sqy (.clk_i, .en_i(en), .a_i(ay_q), .b_i(ay_q), .p_o(sqy));
  vml_mul #(.AW(W), .BW(W)) u_sqz (.clk_i, .en_i(en), .a_i(az_q), .b_i(az_q), .p_o(sqz));
  vml_mul #(.AW(W), .BW(W)) u_sqe (.clk_i, .en_i(en), .a_i(ae_q), .b_i(ae_q), .p_o(sqe));
  vml_mul #(.AW(W), .BW(W)) u_prx (.clk_i, .en_i(en), .a_i(ae_q), .b_i(ax_q), .p_o(prx));
  vml_mul #(.AW(W), .BW(W)) u_pry (.clk_i, .en_i(en), .a_i(ae_q), .b_i(ay_q), .p_o(pry));
  vml_mul #(.AW(W), .BW(W)) u_prz (.clk_i, .en_i(en), .a_i(ae_q), .b_i(az_q), .p_o(prz));

  logic [SA-1:0] side_a, side_c;
  logic          c_vld, c_ne, c_nx, c_ny, c_nz;
  logic [W-1:0]  c_rx, c_ry, c_rz;

  assign side_a = {a_vld_q, ne_q, nx_q, ny_q, nz_q, rx_q, ry_q, rz_q};
  assign {c_vld, c_ne, c_nx, c_ny, c_nz, c_rx, c_ry, c_rz} = side_c;

  vml_delay #(.WIDTH(SA), .DEPTH(2)) u_dly_a (
    .clk_i, .rst_ni, .en_i(en), .data_i(side_a), .data_o(side_c)
  );

  // limit compare
  logic [2*W-1:0] sum;
  logic [2*W-1:0] sum_q;
  logic [SD-1:0]  side_d_q, side_s;

  assign sum = sqx + sqy + sqz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_d_q <= '0;
    end else if (en) begin
      side_d_q <= {c_vld, c_ne || (sum > sqe), c_ne, c_nx, c_ny, c_nz,
                   prx[NW-1:0], pry[NW-1:0], prz[NW-1:0], c_rx, c_ry, c_rz};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum;
    end
  end

  // magnitude
  logic [W-1:0] mag;

  vml_sqrt #(.W(W)) u_sqrt (.clk_i, .en_i(en), .rad_i(sum_q), .root_o(mag));

  vml_delay #(.WIDTH(SD), .DEPTH(W)) u_dly_d (
    .clk_i, .rst_ni, .en_i(en), .data_i(side_d_q), .data_o(side_s)
  );

  logic          s_vld, s_lim, s_ne, s_nx, s_ny, s_nz;
  logic [NW-1:0] s_px, s_py, s_pz;
  logic [W-1:0]  s_rx, s_ry, s_rz;
  logic [DW-1:0] mag_x, floor_x, den;

  assign {s_vld, s_lim, s_ne, s_nx, s_ny, s_nz, s_px, s_py, s_pz, s_rx, s_ry, s_rz} = side_s;
  assign mag_x   = DW'(mag);
  assign floor_x = DW'(floor_eff);
  assign den     = (mag_x > floor_x) ? mag_x : floor_x;

  // divider lanes
  logic [NW-1:0] qx, qy, qz;

  vml_div #(.NW(NW), .DW(DW)) u_div_x (.clk_i, .en_i(en), .num_i(s_px), .den_i(den), .quo_o(qx));
  vml_div #(.NW(NW), .DW(DW)) u_div_y (.clk_i, .en_i(en), .num_i(s_py), .den_i(den), .quo_o(qy));
  vml_div #(.NW(NW), .DW(DW)) u_div_z (.clk_i, .en_i(en), .num_i(s_pz), .den_i(den), .quo_o(qz));

  logic [SS-1:0] side_q;
  logic          q_vld, q_lim, q_ne, q_nx, q_ny, q_nz;
  logic [W-1:0]  q_rx, q_ry, q_rz;

  vml_delay #(.WIDTH(SS), .DEPTH(NW)) u_dly_s (
    .clk_i, .rst_ni, .en_i(en),
    .data_i({s_vld, s_lim, s_ne, s_nx, s_ny, s_nz, s_rx, s_ry, s_rz}),
    .data_o(side_q)
  );

  assign {q_vld, q_lim, q_ne, q_nx, q_ny, q_nz, q_rx, q_ry, q_rz} = side_q;

  // merge lanes into the output register
  logic [W-1:0] out_x_q, out_y_q, out_z_q;
  logic         lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lim_q   <= q_lim;
      out_x_q <= q_lim ? sat(qx, q_ne ^ q_nx) : q_rx;
      out_y_q <= q_lim ? sat(qy, q_ne ^ q_ny) : q_ry;
      out_z_q <= q_lim ? sat(qz, q_ne ^ q_nz) : q_rz;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign was_limited_o = lim_q;

endmodule
